/* hdl/lcw_pkg.sv */
// Shared types and constants for the load-cell tare/span weigher.
// Used by lcw_div, lcw_mul and load_cell_tare_span_weigher; no dependencies.
package lcw_pkg;

    localparam int SAMPLE_W = 24;   // converter sample, signed
    localparam int SUM_W    = 29;   // running sum of one run, signed
    localparam int CNT_W    = 4;    // samples taken in the current run
    localparam int VAL_W    = 32;   // result value, signed
    localparam int KNOWN_W  = 16;   // calibration mass in grams

    localparam int DIV_W    = 48;   // dividend / quotient magnitude
    localparam int DEN_W    = 24;   // divisor magnitude
    localparam int MUL_A_W  = 24;   // |avg - tare|
    localparam int MUL_B_W  = 23;   // known_weight_g * 100

    localparam logic [1:0] FUNC_TARE  = 2'd0;
    localparam logic [1:0] FUNC_CAL   = 2'd1;
    localparam logic [1:0] FUNC_WEIGH = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [KNOWN_W-1:0] KNOWN_RESET = 16'd4650;

    localparam logic [DIV_W-1:0] SAT_POS_LIM = 48'd2147483647;
    localparam logic [DIV_W-1:0] SAT_NEG_LIM = 48'd2147483648;
    localparam logic [VAL_W-1:0] VAL_MAX     = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN     = 32'h8000_0000;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;   // one-cycle pulse after the last step
    } unit_stat_t;

endpackage

/* hdl/lcw_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// Depends on lcw_pkg (widths, unit_stat_t).
module lcw_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lcw_pkg::DIV_W-1:0]    dividend,
    input  logic [lcw_pkg::DEN_W-1:0]    divisor,
    output logic [lcw_pkg::DIV_W-1:0]    quotient,
    output lcw_pkg::unit_stat_t          stat
);

    localparam int STEP_W = $clog2(lcw_pkg::DIV_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(lcw_pkg::DIV_W - 1);

    logic [lcw_pkg::DIV_W-1:0] q_reg;
    logic [lcw_pkg::DEN_W-1:0] rem_reg;
    logic [lcw_pkg::DEN_W-1:0] den_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [lcw_pkg::DEN_W:0]   rem_sh;
    logic [lcw_pkg::DEN_W+1:0] trial;
    logic                      fits;
    logic [lcw_pkg::DEN_W-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[lcw_pkg::DIV_W-1]};
        trial    = {1'b0, rem_sh} - {2'b00, den_reg};
        fits     = !trial[lcw_pkg::DEN_W+1];
        rem_next = fits ? trial[lcw_pkg::DEN_W-1:0] : rem_sh[lcw_pkg::DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[lcw_pkg::DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* hdl/lcw_mul.sv */
// Serial shift-add multiplier, one multiplier bit per cycle, unsigned.
// Depends on lcw_pkg (widths, unit_stat_t).
module lcw_mul
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [lcw_pkg::MUL_A_W-1:0]               mcand,
    input  logic [lcw_pkg::MUL_B_W-1:0]               mplier,
    output logic [lcw_pkg::MUL_A_W+lcw_pkg::MUL_B_W-1:0] product,
    output lcw_pkg::unit_stat_t                       stat
);

    localparam int STEP_W = $clog2(lcw_pkg::MUL_B_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(lcw_pkg::MUL_B_W - 1);

    logic [lcw_pkg::MUL_A_W-1:0] hi_reg;
    logic [lcw_pkg::MUL_B_W-1:0] lo_reg;
    logic [lcw_pkg::MUL_A_W-1:0] a_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [lcw_pkg::MUL_A_W:0]   psum;

    // add the partial product into the high half, then shift the pair right
    assign psum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= mplier;
            a_reg  <= mcand;
        end
        else if (busy_reg)
        begin
            hi_reg <= psum[lcw_pkg::MUL_A_W:1];
            lo_reg <= {psum[0], lo_reg[lcw_pkg::MUL_B_W-1:1]};
        end
    end

    assign product   = {hi_reg, lo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* hdl/load_cell_tare_span_weigher.sv */
// Load-cell tare / span / weigh block, top level.
// Depends on lcw_pkg, lcw_div and lcw_mul.
//
// Input channel (in_valid / in_stall): one transfer per converter sample with a
// function code (tare, calibrate, weigh; code 3 is dropped). Samples of one
// run are summed; a change of function code starts a new run. A sample that
// does not finish a run leaves the input open for the next one. The sample that
// finishes a run starts the work: the mean is formed by a bit-serial divider;
// tare and calibrate runs store it and report it. A weigh run then multiplies
// |avg - tare| by known_weight_g * 100 in a serial shift-add unit and divides
// by |span - tare| in the same divider; if span equals tare it skips both and
// reports 0 with span_valid low. in_stall stays high during this work.
// Output channel (out_valid / out_stall): one transfer per finished run. The
// result sits in an output register; while the receiver stalls it holds, new
// samples are still taken, and a later result waits until the register frees.
// APB port: known_weight_g at byte address 0.
// Reset clears the run, both stored levels and out_valid, and restores
// known_weight_g to 4650 g.
module load_cell_tare_span_weigher
#(
    parameter int CAL_SAMPLES   = 10,
    parameter int WEIGH_SAMPLES = 3
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [1:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           func,
    input  logic signed [lcw_pkg::SAMPLE_W-1:0]  raw_sample,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           result_kind,
    output logic signed [lcw_pkg::VAL_W-1:0]     result_value,
    output logic                                 span_valid
);

    localparam int SW  = lcw_pkg::SAMPLE_W;
    localparam int CW  = lcw_pkg::CNT_W;
    localparam int DW  = lcw_pkg::DIV_W;
    localparam int NW  = lcw_pkg::DEN_W;
    localparam int PW  = lcw_pkg::MUL_A_W + lcw_pkg::MUL_B_W;

    localparam logic [CW-1:0] CAL_NEED   = (CAL_SAMPLES < 1)   ? CW'(1) : CW'(CAL_SAMPLES);
    localparam logic [CW-1:0] WEIGH_NEED = (WEIGH_SAMPLES < 1) ? CW'(1) : CW'(WEIGH_SAMPLES);

    localparam logic [1:0] ADDR_KNOWN = 2'd0;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_AVG  = 6'b000010,
        S_PREP = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg;

    logic [lcw_pkg::SUM_W-1:0]   sum_reg;
    logic [CW-1:0]               count_reg;
    logic [1:0]                  run_mode_reg;
    logic [SW-1:0]               tare_reg;
    logic [SW-1:0]               span_reg;
    logic [lcw_pkg::KNOWN_W-1:0] known_reg;

    logic                        sum_neg_reg;
    logic [SW-1:0]               avg_reg;
    logic                        neg_reg;
    logic [NW-1:0]               den_mag_reg;

    logic [1:0]                  res_kind_reg;
    logic [lcw_pkg::VAL_W-1:0]   res_value_reg;
    logic                        res_span_reg;

    logic                        out_valid_reg;
    logic [1:0]                  out_kind_reg;
    logic [lcw_pkg::VAL_W-1:0]   out_value_reg;
    logic                        out_span_reg;

    // ---- configuration port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_KNOWN);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_KNOWN) ? {16'd0, known_reg} : 32'd0;

    // ---- sample accumulation
    logic                      accept;
    logic                      restart;
    logic [lcw_pkg::SUM_W-1:0] sum_next;
    logic [CW-1:0]             count_next;
    logic [CW-1:0]             need;
    logic                      final_sample;
    logic [lcw_pkg::SUM_W-1:0] sum_mag;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall && (func != lcw_pkg::FUNC_NONE);

    always_comb
    begin
        restart    = (func != run_mode_reg) || (count_reg == '0);
        sum_next   = (restart ? '0 : sum_reg)
                     + {{(lcw_pkg::SUM_W-SW){raw_sample[SW-1]}}, raw_sample};
        count_next = (restart ? '0 : count_reg) + 1'b1;
        need       = (func == lcw_pkg::FUNC_WEIGH) ? WEIGH_NEED : CAL_NEED;
        final_sample = accept && (count_next >= need);
        sum_mag    = sum_next[lcw_pkg::SUM_W-1] ? (~sum_next + 1'b1) : sum_next;
    end

    // ---- arithmetic units
    lcw_pkg::unit_stat_t div_stat;
    lcw_pkg::unit_stat_t mul_stat;
    logic                div_start;
    logic [DW-1:0]       div_dividend;
    logic [NW-1:0]       div_divisor;
    logic [DW-1:0]       div_quot;
    logic                mul_start;
    logic [PW-1:0]       mul_prod;

    logic [SW:0]                 diff;
    logic [SW:0]                 den;
    logic [SW:0]                 diff_mag;
    logic [SW:0]                 den_mag;
    logic [lcw_pkg::MUL_B_W-1:0] k100;
    logic [SW-1:0]               avg_w;

    always_comb
    begin
        diff     = {avg_reg[SW-1], avg_reg} - {tare_reg[SW-1], tare_reg};
        den      = {span_reg[SW-1], span_reg} - {tare_reg[SW-1], tare_reg};
        diff_mag = diff[SW] ? (~diff + 1'b1) : diff;
        den_mag  = den[SW] ? (~den + 1'b1) : den;
        // known * 100 = known * (64 + 32 + 4)
        k100     = ({7'd0, known_reg} << 6) + ({7'd0, known_reg} << 5)
                   + ({7'd0, known_reg} << 2);
        avg_w    = sum_neg_reg ? (~div_quot[SW-1:0] + 1'b1) : div_quot[SW-1:0];
    end

    assign mul_start = (state_reg == S_PREP) && (den != '0);
    assign div_start = final_sample || ((state_reg == S_MUL) && mul_stat.done);

    always_comb
    begin
        if (state_reg == S_MUL)
        begin
            div_dividend = {{(DW-PW){1'b0}}, mul_prod};
            div_divisor  = den_mag_reg;
        end
        else
        begin
            div_dividend = {{(DW-lcw_pkg::SUM_W){1'b0}}, sum_mag};
            div_divisor  = {{(NW-CW){1'b0}}, need};
        end
    end

    lcw_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    lcw_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (diff_mag[SW-1:0]),
        .mplier  (k100),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    // ---- output register
    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // ---- control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            run_mode_reg  <= lcw_pkg::FUNC_TARE;
            tare_reg      <= '0;
            span_reg      <= '0;
            known_reg     <= lcw_pkg::KNOWN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                known_reg <= pwdata[lcw_pkg::KNOWN_W-1:0];

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        run_mode_reg <= func;
                        if (final_sample)
                        begin
                            sum_reg   <= '0;
                            count_reg <= '0;
                            state_reg <= S_AVG;
                        end
                        else
                        begin
                            sum_reg   <= sum_next;
                            count_reg <= count_next;
                        end
                    end
                end
                S_AVG:
                begin
                    if (div_stat.done)
                    begin
                        if (run_mode_reg == lcw_pkg::FUNC_TARE)
                        begin
                            tare_reg  <= avg_w;
                            state_reg <= S_OUT;
                        end
                        else if (run_mode_reg == lcw_pkg::FUNC_CAL)
                        begin
                            span_reg  <= avg_w;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    state_reg <= (den == '0) ? S_OUT : S_MUL;
                end
                S_MUL:
                begin
                    if (mul_stat.done)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_stat.done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (final_sample)
            sum_neg_reg <= sum_next[lcw_pkg::SUM_W-1];

        if ((state_reg == S_AVG) && div_stat.done)
        begin
            avg_reg      <= avg_w;
            res_kind_reg <= run_mode_reg;
            res_value_reg <= {{(lcw_pkg::VAL_W-SW){avg_w[SW-1]}}, avg_w};
            if (run_mode_reg == lcw_pkg::FUNC_TARE)
                res_span_reg <= (span_reg != avg_w);
            else
                res_span_reg <= (avg_w != tare_reg);
        end

        if (state_reg == S_PREP)
        begin
            neg_reg       <= diff[SW] ^ den[SW];
            den_mag_reg   <= den_mag[NW-1:0];
            res_span_reg  <= (den != '0);
            res_value_reg <= '0;
        end

        if ((state_reg == S_DIV) && div_stat.done)
        begin
            if (neg_reg)
                res_value_reg <= (div_quot > lcw_pkg::SAT_NEG_LIM) ? lcw_pkg::VAL_MIN
                                 : (~div_quot[lcw_pkg::VAL_W-1:0] + 1'b1);
            else
                res_value_reg <= (div_quot > lcw_pkg::SAT_POS_LIM) ? lcw_pkg::VAL_MAX
                                 : div_quot[lcw_pkg::VAL_W-1:0];
        end

        if (out_load)
        begin
            out_kind_reg  <= res_kind_reg;
            out_value_reg <= res_value_reg;
            out_span_reg  <= res_span_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign result_value = out_value_reg;
    assign span_valid   = out_span_reg;

    // ---- checks
    a_count_below_need: assert property (@(posedge clk) disable iff (!rst_n)
        (run_mode_reg != lcw_pkg::FUNC_WEIGH || count_reg < WEIGH_NEED) &&
        (run_mode_reg == lcw_pkg::FUNC_WEIGH || count_reg < CAL_NEED))
        else $error("run count reached its target without a result");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || mul_stat.busy) |-> in_stall)
        else $error("input open while arithmetic in progress");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_AVG || state_reg == S_DIV))
        else $error("divider finished outside a divide step");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench for load_cell_tare_span_weigher: random and directed sample runs,
// APB writes of known_weight_g, and a scoreboard that predicts every result.
// Depends on lcw_pkg and the RTL of the block; nothing else.
module tb;

    localparam int CAL_RUN        = 10;
    localparam int WEIGH_RUN      = 3;
    localparam int SAMPLE_TARGET  = 1050;
    localparam int PHASES         = 5;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [1:0] REG_KNOWN_WEIGHT = 2'd0;

    typedef logic signed [lcw_pkg::SAMPLE_W-1:0] sample_t;
    typedef logic [lcw_pkg::KNOWN_W-1:0]         known_t;

    localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
    localparam sample_t SAMPLE_MIN = 24'sh800000;
    localparam longint WEIGHT_MAX = 2147483647;
    localparam longint WEIGHT_MIN = -WEIGHT_MAX - 1;

    // how the samples of one run are chosen
    localparam int FLAVOR_UNIFORM = 0;
    localparam int FLAVOR_FIXED   = 1;
    localparam int FLAVOR_NEAR    = 2;

    typedef struct {
        logic [1:0]                       kind;
        logic signed [lcw_pkg::VAL_W-1:0] value;
        logic                             span_ok;
    } weigh_result_t;

    class weigh_scoreboard;
        longint                     run_sum;
        int                         run_count;
        logic [1:0]                 run_func;
        sample_t                    tare_level;
        sample_t                    span_level;
        known_t                     known_g;
        weigh_result_t              expected_results[$];
        int                         mismatches;
        int                         checked_by_kind[4];
        int                         saturated;
        int                         flat_span;

        function new();
            run_sum    = 0;
            run_count  = 0;
            run_func   = lcw_pkg::FUNC_TARE;
            tare_level = '0;
            span_level = '0;
            known_g    = lcw_pkg::KNOWN_RESET;
            mismatches = 0;
            saturated  = 0;
            flat_span  = 0;
            foreach (checked_by_kind[k])
                checked_by_kind[k] = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t  mismatch: %s", $time, msg);
        endfunction

        function void note_sample(logic [1:0] f, sample_t s);
            longint        need;
            longint        avg;
            longint        den;
            longint        weight;
            weigh_result_t r;
            if (f == lcw_pkg::FUNC_NONE)
                return;
            if (f != run_func || run_count == 0)
            begin
                run_func  = f;
                run_sum   = 0;
                run_count = 0;
            end
            run_sum += longint'(s);
            run_count++;
            need = (f == lcw_pkg::FUNC_WEIGH) ? WEIGH_RUN : CAL_RUN;
            if (run_count < need)
                return;
            avg       = run_sum / need;   // truncates toward zero
            run_sum   = 0;
            run_count = 0;
            case (f)
                lcw_pkg::FUNC_TARE:
                begin
                    tare_level = avg[lcw_pkg::SAMPLE_W-1:0];
                    weight     = avg;
                end
                lcw_pkg::FUNC_CAL:
                begin
                    span_level = avg[lcw_pkg::SAMPLE_W-1:0];
                    weight     = avg;
                end
                default:
                begin
                    den = longint'(span_level) - longint'(tare_level);
                    if (den == 0)
                    begin
                        weight = 0;
                        flat_span++;
                    end
                    else
                        weight = (avg - longint'(tare_level)) * longint'(known_g) * 100 / den;
                    if (weight > WEIGHT_MAX || weight < WEIGHT_MIN)
                        saturated++;
                    if (weight > WEIGHT_MAX)
                        weight = WEIGHT_MAX;
                    if (weight < WEIGHT_MIN)
                        weight = WEIGHT_MIN;
                end
            endcase
            r.kind    = f;
            r.value   = weight[lcw_pkg::VAL_W-1:0];
            r.span_ok = (span_level != tare_level);
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] kind,
                                   logic signed [lcw_pkg::VAL_W-1:0] value,
                                   logic span_ok);
            weigh_result_t want;
            if (expected_results.size() == 0)
            begin
                flag($sformatf("result with nothing pending: kind %0d value %0d", kind, value));
                return;
            end
            want = expected_results.pop_front();
            checked_by_kind[kind]++;
            if (kind !== want.kind)
                flag($sformatf("result_kind expected %0d, got %0d", want.kind, kind));
            if (value !== want.value)
                flag($sformatf("result_value (kind %0d) expected %0d, got %0d",
                               want.kind, want.value, value));
            if (span_ok !== want.span_ok)
                flag($sformatf("span_valid expected %0d, got %0d", want.span_ok, span_ok));
        endfunction
    endclass

    logic                             clk        = 1'b0;
    logic                             rst_n      = 1'b0;
    logic                             psel       = 1'b0;
    logic                             penable    = 1'b0;
    logic                             pwrite     = 1'b0;
    logic [1:0]                       paddr      = '0;
    logic [31:0]                      pwdata     = '0;
    logic [31:0]                      prdata;
    logic                             pready;
    logic                             in_valid   = 1'b0;
    logic                             in_stall;
    logic [1:0]                       func       = '0;
    sample_t                          raw_sample = '0;
    logic                             out_valid;
    logic                             out_stall  = 1'b0;
    logic [1:0]                       result_kind;
    logic signed [lcw_pkg::VAL_W-1:0] result_value;
    logic                             span_valid;

    weigh_scoreboard sb = new();

    bit burst;          // no idling on either side while set
    bit hold_drawn;
    int out_hold;
    int samples_sent;
    int codes_dropped;
    int quiet_cycles;

    load_cell_tare_span_weigher u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .raw_sample   (raw_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .result_value (result_value),
        .span_valid   (span_valid)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(result_kind, result_value, span_valid);
            hold_drawn = 1'b0;
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall, drawn once per presented result
    always @(negedge clk)
    begin
        if (out_valid === 1'b1 && !hold_drawn)
        begin
            out_hold   = burst ? 0 : $urandom_range(0, 6);
            hold_drawn = 1'b1;
        end
        out_stall <= (out_hold > 0);
        if (out_hold > 0)
            out_hold--;
    end

    task automatic send_sample(input logic [1:0] f, input sample_t s);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        raw_sample <= s;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_sample(f, s);
        if (f == lcw_pkg::FUNC_NONE)
            codes_dropped++;
        else
            samples_sent++;
    endtask

    // one run of samples; an unused code now and then lands before one of its samples
    task automatic send_run(input logic [1:0] f, input int len, input int flavor,
                            input sample_t level, input int spread);
        sample_t s;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_sample(lcw_pkg::FUNC_NONE, sample_t'($urandom()));
            case (flavor)
                FLAVOR_UNIFORM: s = sample_t'($urandom());
                FLAVOR_FIXED:   s = level;
                default:        s = sample_t'(int'(level)
                                    + int'($urandom_range(0, 2 * spread)) - spread);
            endcase
            send_sample(f, s);
        end
    endtask

    // drain every pending result, then let a run still in the datapath finish
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write known_weight_g, then read it back
    task automatic set_known_weight(input known_t grams);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_KNOWN_WEIGHT;
        pwdata  <= {16'b0, grams};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.known_g = grams;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {16'b0, grams})
            sb.flag($sformatf("known_weight_g readback expected %0d, got %0d", grams, rd));
    endtask

    initial
    begin
        known_t                     phase_weight [PHASES];
        logic [1:0]                 f;
        sample_t                    anchor;
        sample_t                    level;
        int                         len;
        int                         need;
        int                         flavor;
        int                         spread;
        int                         target;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: weigh with span equal to tare, dropped codes, a run broken
        // by a mode change, tare at full scale low, then a full scale weigh
        burst = 1'b0;
        send_sample(lcw_pkg::FUNC_WEIGH, SAMPLE_MAX);
        send_sample(lcw_pkg::FUNC_WEIGH, SAMPLE_MIN);
        send_sample(lcw_pkg::FUNC_WEIGH, '0);
        send_sample(lcw_pkg::FUNC_NONE, SAMPLE_MAX);
        send_sample(lcw_pkg::FUNC_NONE, SAMPLE_MIN);
        send_sample(lcw_pkg::FUNC_CAL, 24'sd1000);
        send_sample(lcw_pkg::FUNC_CAL, -24'sd1000);
        send_run(lcw_pkg::FUNC_TARE, CAL_RUN, FLAVOR_FIXED, SAMPLE_MIN, 0);
        send_run(lcw_pkg::FUNC_WEIGH, WEIGH_RUN, FLAVOR_FIXED, SAMPLE_MAX, 0);

        phase_weight[0] = 16'hFFFF;
        phase_weight[1] = 16'd0;
        phase_weight[2] = 16'd1;
        phase_weight[3] = known_t'($urandom_range(2, 65534));
        phase_weight[4] = lcw_pkg::KNOWN_RESET;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            set_known_weight(phase_weight[p]);
            // tare and span runs near one level give tiny or zero spans
            anchor = sample_t'(int'($urandom_range(0, 16000000)) - 8000000);
            target = samples_sent + (SAMPLE_TARGET - samples_sent) / (PHASES - p);
            while (samples_sent < target)
            begin
                burst = ($urandom_range(0, 7) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2: f = lcw_pkg::FUNC_TARE;
                    3, 4, 5: f = lcw_pkg::FUNC_CAL;
                    default: f = lcw_pkg::FUNC_WEIGH;
                endcase
                need = (f == lcw_pkg::FUNC_WEIGH) ? WEIGH_RUN : CAL_RUN;
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, need - 1) : need;
                flavor = $urandom_range(0, 3);
                if (flavor > FLAVOR_NEAR)
                    flavor = FLAVOR_NEAR;
                level  = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                if (flavor == FLAVOR_NEAR)
                    level = anchor;
                case ($urandom_range(0, 2))
                    0:       spread = 0;
                    1:       spread = 3;
                    default: spread = 500;
                endcase
                send_run(f, len, flavor, level, spread);
            end
        end

        burst = 1'b0;
        wait_idle();

        $display("Sent %0d samples and %0d unused codes across %0d weight settings.",
                 samples_sent, codes_dropped, PHASES + 1);
        $display("Checked %0d tare, %0d span, %0d weight results (%0d saturated, %0d flat span).",
                 sb.checked_by_kind[lcw_pkg::FUNC_TARE], sb.checked_by_kind[lcw_pkg::FUNC_CAL],
                 sb.checked_by_kind[lcw_pkg::FUNC_WEIGH], sb.saturated, sb.flat_span);
        if (sb.expected_results.size() != 0)
            $display("%0d expected results never arrived", sb.expected_results.size());
        if (sb.mismatches != 0)
            $display("%0d mismatches in total", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/lcw_pkg.sv
hdl/lcw_div.sv
hdl/lcw_mul.sv
hdl/load_cell_tare_span_weigher.sv
verif/tb.sv
